// ===== sv/m3i_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;

  localparam int DIM           = 3;
  localparam int NUM_EL        = DIM * DIM;
  localparam int ELEM_W        = 16;
  localparam int CMAG_W        = 32;
  localparam int DMAG_W        = 49;
  localparam int QUO_W         = 33;
  localparam int RES_W         = 32;
  localparam int IN_FRAC_BITS  = 8;
  localparam int OUT_FRAC_BITS = 16;

  // cofactor magnitudes and determinant magnitude, ready for division
  typedef struct packed {
    logic [NUM_EL-1:0][CMAG_W-1:0] cmag;
    logic [NUM_EL-1:0]             cneg;
    logic [DMAG_W-1:0]             dmag;
    logic                          dneg;
    logic                          dzero;
  } m3i_ratio_t;

  // rounded quotient magnitudes with sign and overflow per element
  typedef struct packed {
    logic [NUM_EL-1:0][QUO_W:0] qmag;
    logic [NUM_EL-1:0]          neg;
    logic [NUM_EL-1:0]          ovf;
    logic                       dzero;
  } m3i_quot_t;

endpackage
`default_nettype wire

// ===== sv/m3i_cofactor.sv =====
`timescale 1ns / 1ps
`default_nettype none
module m3i_cofactor (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic [m3i_pkg::NUM_EL-1:0][m3i_pkg::ELEM_W-1:0] in_m,
  output logic                                              out_valid,
  input  wire logic                                         out_ready,
  output m3i_pkg::m3i_ratio_t                               out_ratio
);

  localparam int NE    = m3i_pkg::NUM_EL;
  localparam int EW    = m3i_pkg::ELEM_W;
  localparam int PW    = 2 * EW;
  localparam int AW    = PW + 1;
  localparam int TW    = m3i_pkg::DMAG_W;
  localparam int DW    = TW + 1;
  localparam int NSTG  = 5;
  // adjugate element k = m[PA]*m[PB] - m[PC]*m[PD]
  localparam int PA [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PB [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int PC [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int PD [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   adv;

  logic signed [PW-1:0] pa_r [NE];
  logic signed [PW-1:0] pb_r [NE];
  logic signed [EW-1:0] m0_r [m3i_pkg::DIM];
  logic signed [AW-1:0] adj_r [NE];
  logic signed [EW-1:0] m0b_r [m3i_pkg::DIM];
  logic signed [AW-1:0] adjb_r [NE];
  logic signed [TW-1:0] t_r [m3i_pkg::DIM];
  logic signed [DW-1:0] det_r;
  logic [NE-1:0][m3i_pkg::CMAG_W-1:0] cmag_r;
  logic [NE-1:0]                      cneg_r;
  m3i_pkg::m3i_ratio_t ratio_r;

  assign adv[NSTG] = out_ready;
  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_adv
      assign adv[g] = !vld_r[g] || adv[g+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= (i == 0) ? in_valid : vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < NE; k++) begin
        pa_r[k] <= $signed(in_m[PA[k]]) * $signed(in_m[PB[k]]);
        pb_r[k] <= $signed(in_m[PC[k]]) * $signed(in_m[PD[k]]);
      end
      for (int j = 0; j < m3i_pkg::DIM; j++) begin
        m0_r[j] <= $signed(in_m[j]);
      end
    end
    if (adv[1]) begin
      for (int k = 0; k < NE; k++) begin
        adj_r[k] <= AW'(pa_r[k]) - AW'(pb_r[k]);
      end
      m0b_r <= m0_r;
    end
    if (adv[2]) begin
      // expand along row 0: adjugate elements 0, 3, 6 are that row's cofactors
      for (int j = 0; j < m3i_pkg::DIM; j++) begin
        t_r[j] <= TW'(m0b_r[j]) * TW'(adj_r[m3i_pkg::DIM * j]);
      end
      adjb_r <= adj_r;
    end
    if (adv[3]) begin
      det_r <= DW'(t_r[0]) + DW'(t_r[1]) + DW'(t_r[2]);
      for (int k = 0; k < NE; k++) begin
        cneg_r[k] <= adjb_r[k][AW-1];
        cmag_r[k] <= m3i_pkg::CMAG_W'(adjb_r[k][AW-1] ? -adjb_r[k] : adjb_r[k]);
      end
    end
    if (adv[4]) begin
      ratio_r.cmag  <= cmag_r;
      ratio_r.cneg  <= cneg_r;
      ratio_r.dneg  <= det_r[DW-1];
      ratio_r.dmag  <= TW'(det_r[DW-1] ? -det_r : det_r);
      ratio_r.dzero <= (det_r == '0);
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_ratio = ratio_r;

endmodule
`default_nettype wire

// ===== sv/m3i_divide.sv =====
`timescale 1ns / 1ps
`default_nettype none
module m3i_divide #(
  parameter int IN_FRAC_BITS  = m3i_pkg::IN_FRAC_BITS,
  parameter int OUT_FRAC_BITS = m3i_pkg::OUT_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire m3i_pkg::m3i_ratio_t in_ratio,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output m3i_pkg::m3i_quot_t      out_quot
);

  localparam int NE   = m3i_pkg::NUM_EL;
  localparam int CW   = m3i_pkg::CMAG_W;
  localparam int DMW  = m3i_pkg::DMAG_W;
  localparam int QB   = m3i_pkg::QUO_W;
  localparam int SH   = IN_FRAC_BITS + OUT_FRAC_BITS;
  localparam int XW   = CW + SH + QB;
  localparam int RW   = DMW + 1;
  localparam int LAST = QB + 1;

  logic [LAST:0]   vld_r;
  logic [LAST+1:0] adv;

  logic [CW-1:0]  cm_r  [QB+1][NE];
  logic [RW-1:0]  rem_r [QB+1][NE];
  logic [QB-1:0]  q_r   [QB+1][NE];
  logic [DMW-1:0] d_r   [QB+1];
  logic [NE-1:0]  neg_r [QB+1];
  logic [NE-1:0]  ovf_r [QB+1];
  logic           dz_r  [QB+1];
  m3i_pkg::m3i_quot_t quot_r;

  assign adv[LAST+1] = out_ready;
  genvar g, l;
  generate
    for (g = 0; g <= LAST; g++) begin : g_adv
      assign adv[g] = !vld_r[g] || adv[g+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i <= LAST; i++) begin
        if (adv[i]) begin
          vld_r[i] <= (i == 0) ? in_valid : vld_r[i-1];
        end
      end
    end
  end

  // first stage: flag quotients of more than QB bits, seed the partial remainder
  generate
    for (l = 0; l < NE; l++) begin : g_init
      logic [XW-1:0] num_x;
      logic [XW-1:0] hi;
      logic          ovf;
      assign num_x = XW'(in_ratio.cmag[l]) << SH;
      assign hi    = num_x >> QB;
      assign ovf   = hi >= XW'(in_ratio.dmag);
      always_ff @(posedge clk) begin
        if (adv[0]) begin
          cm_r[0][l]  <= in_ratio.cmag[l];
          rem_r[0][l] <= ovf ? '0 : hi[RW-1:0];
          q_r[0][l]   <= '0;
          neg_r[0][l] <= in_ratio.cneg[l] ^ in_ratio.dneg;
          ovf_r[0][l] <= ovf;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d_r[0]  <= in_ratio.dmag;
      dz_r[0] <= in_ratio.dzero;
    end
  end

  // one quotient bit per stage, most significant first
  generate
    for (g = 1; g <= QB; g++) begin : g_step
      localparam int K = QB - g;
      for (l = 0; l < NE; l++) begin : g_lane
        logic          nbit;
        logic [RW-1:0] sh;
        logic          ge;
        if (K >= SH && K - SH < CW) begin : g_bit
          assign nbit = cm_r[g-1][l][K-SH];
        end else begin : g_zero
          assign nbit = 1'b0;
        end
        assign sh = {rem_r[g-1][l][RW-2:0], nbit};
        assign ge = sh >= RW'(d_r[g-1]);
        always_ff @(posedge clk) begin
          if (adv[g]) begin
            cm_r[g][l]  <= cm_r[g-1][l];
            rem_r[g][l] <= ge ? sh - RW'(d_r[g-1]) : sh;
            q_r[g][l]   <= {q_r[g-1][l][QB-2:0], ge};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (adv[g]) begin
          d_r[g]   <= d_r[g-1];
          neg_r[g] <= neg_r[g-1];
          ovf_r[g] <= ovf_r[g-1];
          dz_r[g]  <= dz_r[g-1];
        end
      end
    end
  endgenerate

  // round to nearest, ties away from zero
  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      for (int k = 0; k < NE; k++) begin
        quot_r.qmag[k] <= (QB + 1)'(q_r[QB][k]) +
                          (QB + 1)'({rem_r[QB][k], 1'b0} >= (RW + 1)'(d_r[QB]));
      end
      quot_r.neg   <= neg_r[QB];
      quot_r.ovf   <= ovf_r[QB];
      quot_r.dzero <= dz_r[QB];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[LAST];
  assign out_quot  = quot_r;

endmodule
`default_nettype wire

// ===== sv/matrix3x3_inverse.sv =====
// Pipeline: 5 cofactor/determinant stages, 35 divider stages (seed, one quotient bit
//   per stage, round), 1 output stage.
// Throughput: one matrix per cycle while out_tready is high; every stage holds its own valid bit.
// Reset: rst_n synchronous, active low; clears all valid bits, data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module matrix3x3_inverse #(
  parameter int IN_FRAC_BITS  = m3i_pkg::IN_FRAC_BITS,
  parameter int OUT_FRAC_BITS = m3i_pkg::OUT_FRAC_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22 (32 bits each)
  output logic [287:0]      out_tdata,
  // singular, saturated
  output logic [1:0]        out_tuser
);

  localparam int NE = m3i_pkg::NUM_EL;
  localparam int RW = m3i_pkg::RES_W;
  localparam int QW = m3i_pkg::QUO_W + 1;

  logic                mid_valid, mid_ready;
  m3i_pkg::m3i_ratio_t mid_ratio;
  logic                q_valid, q_ready;
  m3i_pkg::m3i_quot_t  quot;

  logic [NE-1:0][RW-1:0] res_nxt;
  logic [NE-1:0]         sat_nxt;
  logic                  out_vld_r;
  logic [287:0]          out_data_r;
  logic [1:0]            out_user_r;

  m3i_cofactor u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_m      (in_tdata),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_ratio (mid_ratio)
  );

  m3i_divide #(
    .IN_FRAC_BITS  (IN_FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_ratio  (mid_ratio),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_quot  (quot)
  );

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      logic [QW-1:0] lim;
      logic [QW-1:0] v;
      lim = quot.neg[k] ? QW'(1) << (RW - 1) : (QW'(1) << (RW - 1)) - QW'(1);
      sat_nxt[k] = !quot.dzero && (quot.ovf[k] || quot.qmag[k] > lim);
      v = sat_nxt[k] ? lim : quot.qmag[k];
      if (quot.dzero) begin
        res_nxt[k] = '0;
      end else begin
        res_nxt[k] = RW'(quot.neg[k] ? -v : v);
      end
    end
  end

  assign q_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (q_ready) begin
      out_vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      out_data_r <= res_nxt;
      out_user_r <= {|sat_nxt, quot.dzero};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("singular result carries data or saturation");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage empty");

endmodule
`default_nettype wire
